[rtl/core/pesh_pkg.sv]
// ============================================================================
// pesh_pkg
// Types and constants shared by the PES header parser modules.
// ============================================================================
package pesh_pkg;

    // Parser phase, front end
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_PREFIX1 = 4'd1,
        PH_PREFIX2 = 4'd2,
        PH_STREAM  = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_FLAGS1  = 4'd6,
        PH_FLAGS2  = 4'd7,
        PH_HDL     = 4'd8,
        PH_TS      = 4'd9,
        PH_SKIP    = 4'd10
    } phase_t;

    // What the back end does with a queued byte
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_STREAM = 3'd1,
        OP_LEN_HI = 3'd2,
        OP_LEN_LO = 3'd3,
        OP_HDL    = 3'd4,
        OP_TS     = 3'd5
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_BAD_MARKER = 2'd2,
        ST_TOO_SHORT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TSF_NONE     = 2'd0,
        TSF_RESERVED = 2'd1,
        TSF_PTS      = 2'd2,
        TSF_PTS_DTS  = 2'd3
    } ts_flags_t;

    localparam int  TS_W           = 33;
    localparam int  TS_IDX_W       = 4;
    localparam logic [7:0] MARK_MASK = 8'hC0;
    localparam logic [7:0] MARK_BITS = 8'h80;
    localparam logic [7:0] PREFIX_LAST = 8'h01;
    localparam logic [7:0] NEED_PTS  = 8'd5;
    localparam logic [7:0] NEED_BOTH = 8'd10;
    localparam int  Q_DEPTH        = 2;

    typedef struct packed {
        logic [7:0]          data;
        op_kind_t            kind;
        logic [TS_IDX_W-1:0] ts_idx;
        logic                clear_ts;
        logic                copy_dts;
        logic                emit;
        status_t             status;
    } op_t;

endpackage

[rtl/core/pesh_if.sv]
// ============================================================================
// pesh_if
// Request channels: payload bytes in, parsed header results out.
// ============================================================================
interface pesh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       unit_start;

    modport source (output valid, output data_byte, output unit_start, input ready);
    modport sink   (input valid, input data_byte, input unit_start, output ready);
endinterface

interface pesh_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  stream_id;
    logic [15:0] packet_length;
    logic [7:0]  header_data_length;
    logic        has_pts;
    logic        has_dts;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
    logic [1:0]  status;

    modport source (output valid, output stream_id, output packet_length,
                    output header_data_length, output has_pts, output has_dts,
                    output pts_value, output dts_value, output status, input ready);
    modport sink   (input valid, input stream_id, input packet_length,
                    input header_data_length, input has_pts, input has_dts,
                    input pts_value, input dts_value, input status, output ready);
endinterface

[rtl/core/pesh_front.sv]
// ============================================================================
// pesh_front
// Byte sequencer: tracks header position, checks prefix and markers,
// tags each byte it passes on with the operation the back end applies.
// ============================================================================
module pesh_front
    import pesh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pesh_byte_if.sink  bytes,
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    ts_flags_t  flags_reg, flags_next;
    logic [7:0] hdl_reg, hdl_next;

    logic       take;
    logic [7:0] b;
    logic [7:0] need;
    logic [7:0] idx1;
    logic [7:0] count_dec;

    assign bytes.ready = !q_full;
    assign take        = bytes.valid && !q_full;
    assign b           = bytes.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            flags_reg <= TSF_NONE;
            hdl_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            flags_reg <= flags_next;
            hdl_reg   <= hdl_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        flags_next = flags_reg;
        hdl_next   = hdl_reg;
        push       = 1'b0;
        push_op    = '{data: b, kind: OP_NONE, ts_idx: count_reg[TS_IDX_W-1:0],
                       clear_ts: 1'b0, copy_dts: 1'b0, emit: 1'b0, status: ST_OK};
        // timestamp bytes that follow, from the held flags
        unique case (flags_reg)
            TSF_PTS_DTS: need = NEED_BOTH;
            TSF_PTS:     need = NEED_PTS;
            default:     need = 8'd0;
        endcase
        idx1      = count_reg + 8'd1;
        count_dec = (count_reg != 8'd0) ? count_reg - 8'd1 : 8'd0;

        if (take)
        begin
            if (bytes.unit_start)
            begin
                if (b != 8'd0)
                begin
                    push           = 1'b1;
                    push_op.emit   = 1'b1;
                    push_op.status = ST_BAD_PREFIX;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_PREFIX1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_PREFIX1:
                    begin
                        if (b != 8'd0)
                        begin
                            push           = 1'b1;
                            push_op.emit   = 1'b1;
                            push_op.status = ST_BAD_PREFIX;
                            phase_next     = PH_IDLE;
                        end
                        else
                            phase_next = PH_PREFIX2;
                    end
                    PH_PREFIX2:
                    begin
                        if (b != PREFIX_LAST)
                        begin
                            push           = 1'b1;
                            push_op.emit   = 1'b1;
                            push_op.status = ST_BAD_PREFIX;
                            phase_next     = PH_IDLE;
                        end
                        else
                            phase_next = PH_STREAM;
                    end
                    PH_STREAM:
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_STREAM;
                        phase_next   = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_LEN_HI;
                        phase_next   = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        push         = 1'b1;
                        push_op.kind = OP_LEN_LO;
                        phase_next   = PH_FLAGS1;
                    end
                    PH_FLAGS1:
                    begin
                        if ((b & MARK_MASK) != MARK_BITS)
                        begin
                            push           = 1'b1;
                            push_op.emit   = 1'b1;
                            push_op.status = ST_BAD_MARKER;
                            phase_next     = PH_IDLE;
                        end
                        else
                            phase_next = PH_FLAGS2;
                    end
                    PH_FLAGS2:
                    begin
                        flags_next = ts_flags_t'(b[7:6]);
                        phase_next = PH_HDL;
                    end
                    PH_HDL:
                    begin
                        hdl_next         = b;
                        push             = 1'b1;
                        push_op.kind     = OP_HDL;
                        push_op.clear_ts = (flags_reg == TSF_NONE);
                        if (need == 8'd0)
                        begin
                            if (b == 8'd0)
                            begin
                                push_op.emit = 1'b1;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                count_next = b;
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            count_next = 8'd0;
                            phase_next = PH_TS;
                        end
                    end
                    PH_TS:
                    begin
                        push             = 1'b1;
                        push_op.kind     = OP_TS;
                        push_op.copy_dts = (need == NEED_PTS);
                        count_next       = idx1;
                        if (idx1 >= need)
                        begin
                            if (hdl_reg < need)
                            begin
                                push_op.emit   = 1'b1;
                                push_op.status = ST_TOO_SHORT;
                                phase_next     = PH_IDLE;
                            end
                            else if (hdl_reg == need)
                            begin
                                push_op.emit = 1'b1;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                count_next = hdl_reg - need;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        count_next = count_dec;
                        if (count_dec == 8'd0)
                        begin
                            push         = 1'b1;
                            push_op.emit = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        end
    end

endmodule

[rtl/core/pesh_queue.sv]
// ============================================================================
// pesh_queue
// Small FIFO of tagged bytes between sequencer and executor.
// ============================================================================
module pesh_queue
    import pesh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    output logic pop_valid,
    output op_t  pop_op,
    input  logic pop
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    op_t              mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(Q_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_op    = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_op;
    end

endmodule

[rtl/core/pesh_back.sv]
// ============================================================================
// pesh_back
// Executor: holds header fields and timestamps, assembles the result.
// ============================================================================
module pesh_back
    import pesh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    input  op_t           op,
    output logic          pop,
    pesh_result_if.source headers
);

    logic [7:0]      sid_reg, sid_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      hdl_reg, hdl_next;
    logic [TS_W-1:0] pts_reg, pts_next;
    logic [TS_W-1:0] dts_reg, dts_next;
    logic            pts_ok_reg, pts_ok_next;
    logic            dts_ok_reg, dts_ok_next;

    logic            out_valid_reg;
    logic [7:0]      o_sid_reg;
    logic [15:0]     o_len_reg;
    logic [7:0]      o_hdl_reg;
    logic            o_hp_reg, o_hd_reg;
    logic [TS_W-1:0] o_pts_reg, o_dts_reg;
    status_t         o_st_reg;

    logic            slot_free;
    logic [7:0]      b;
    logic [TS_IDX_W-1:0] idx1;
    logic [TS_IDX_W-1:0] k;
    logic [TS_W-1:0] ts_cur, ts_new;

    assign slot_free = !out_valid_reg || headers.ready;
    assign pop       = op_valid && (!op.emit || slot_free);
    assign b         = op.data;
    assign idx1      = op.ts_idx + 1'b1;

    // One timestamp byte into the PTS or DTS field
    always_comb
    begin
        k      = (op.ts_idx < TS_IDX_W'(5)) ? op.ts_idx : op.ts_idx - TS_IDX_W'(5);
        ts_cur = (op.ts_idx < TS_IDX_W'(5)) ? pts_reg : dts_reg;
        ts_new = ts_cur;
        unique case (k)
            TS_IDX_W'(0): ts_new = {b[3:1], 30'd0};
            TS_IDX_W'(1): ts_new[29:22] = b;
            TS_IDX_W'(2): ts_new[21:15] = b[7:1];
            TS_IDX_W'(3): ts_new[14:7]  = b;
            default:      ts_new[6:0]   = b[7:1];
        endcase
    end

    always_comb
    begin
        sid_next    = sid_reg;
        len_next    = len_reg;
        hdl_next    = hdl_reg;
        pts_next    = pts_reg;
        dts_next    = dts_reg;
        pts_ok_next = pts_ok_reg;
        dts_ok_next = dts_ok_reg;
        if (pop)
        begin
            unique case (op.kind)
                OP_STREAM: sid_next = b;
                OP_LEN_HI: len_next = {b, 8'd0};
                OP_LEN_LO: len_next = {len_reg[15:8], b};
                OP_HDL:
                begin
                    hdl_next = b;
                    if (op.clear_ts)
                    begin
                        pts_next    = '0;
                        dts_next    = '0;
                        pts_ok_next = 1'b0;
                        dts_ok_next = 1'b0;
                    end
                end
                OP_TS:
                begin
                    if (op.ts_idx < TS_IDX_W'(5))
                        pts_next = ts_new;
                    else
                        dts_next = ts_new;
                    if (idx1 == TS_IDX_W'(5))
                    begin
                        pts_ok_next = 1'b1;
                        if (op.copy_dts)
                        begin
                            dts_next    = ts_new;
                            dts_ok_next = 1'b1;
                        end
                    end
                    else if (idx1 == TS_IDX_W'(10))
                        dts_ok_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sid_reg    <= '0;
            len_reg    <= '0;
            hdl_reg    <= '0;
            pts_reg    <= '0;
            dts_reg    <= '0;
            pts_ok_reg <= 1'b0;
            dts_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sid_reg    <= sid_next;
            len_reg    <= len_next;
            hdl_reg    <= hdl_next;
            pts_reg    <= pts_next;
            dts_reg    <= dts_next;
            pts_ok_reg <= pts_ok_next;
            dts_ok_reg <= dts_ok_next;
            if (pop && op.emit)
                out_valid_reg <= 1'b1;
            else if (headers.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register; error results carry zero fields
    always_ff @(posedge clk)
    begin
        if (pop && op.emit)
        begin
            o_st_reg <= op.status;
            if (op.status == ST_OK)
            begin
                o_sid_reg <= sid_next;
                o_len_reg <= len_next;
                o_hdl_reg <= hdl_next;
                o_hp_reg  <= pts_ok_next;
                o_hd_reg  <= dts_ok_next;
                o_pts_reg <= pts_next;
                o_dts_reg <= dts_next;
            end
            else
            begin
                o_sid_reg <= '0;
                o_len_reg <= '0;
                o_hdl_reg <= '0;
                o_hp_reg  <= 1'b0;
                o_hd_reg  <= 1'b0;
                o_pts_reg <= '0;
                o_dts_reg <= '0;
            end
        end
    end

    assign headers.valid              = out_valid_reg;
    assign headers.stream_id          = o_sid_reg;
    assign headers.packet_length      = o_len_reg;
    assign headers.header_data_length = o_hdl_reg;
    assign headers.has_pts            = o_hp_reg;
    assign headers.has_dts            = o_hd_reg;
    assign headers.pts_value          = o_pts_reg;
    assign headers.dts_value          = o_dts_reg;
    assign headers.status             = o_st_reg;

endmodule

[rtl/core/pes_header_parser_top.sv]
// ============================================================================
// pes_header_parser_top
// PES header parser: bytes in, one header summary (or error) out per header.
// ============================================================================
//
//  channel   dir  handshake     payload
//  -------   ---  ------------  ----------------------------------------------
//  bytes     in   valid/ready   data_byte[7:0], unit_start
//  headers   out  valid/ready   stream_id, packet_length, header_data_length,
//                               has_pts, has_dts, pts_value, dts_value, status
//
//  One byte per cycle while the queue is not full; the sequencer holds only
//  position state, so each byte is classified in its cycle of arrival.
//  A result passes through the queue, then the result register, after the
//  byte that completes the header.
//  Reset is asynchronous, active low; all parser and held fields clear.
//  A stalled result output backs up the 2-entry queue; bytes stop being
//  taken only when the queue is full.
//
module pes_header_parser_top
    import pesh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pesh_byte_if.sink     bytes,
    pesh_result_if.source headers
);

    // sequencer to queue
    logic push;
    op_t  push_op;
    logic q_full;

    // queue to executor
    logic pop_valid;
    op_t  pop_op;
    logic pop;

    pesh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .q_full  (q_full),
        .push    (push),
        .push_op (push_op)
    );

    pesh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_op    (pop_op),
        .pop       (pop)
    );

    pesh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (pop_valid),
        .op       (pop_op),
        .pop      (pop),
        .headers  (headers)
    );

endmodule
